// File: rtl/sbms_pkg.sv
// ----------------------------------------------------------------------------
// sbms_pkg
// Shared types and constants for the shared-buffer multi-stack.
// ----------------------------------------------------------------------------
package sbms_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int STACKS_DEF     = 8;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int SEL_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

endpackage

// File: rtl/sbms_link_table.sv
// ----------------------------------------------------------------------------
// sbms_link_table
// Per-entry link words. Entries at or above the fill mark have never been
// written and read back as their own index plus one.
// ----------------------------------------------------------------------------
module sbms_link_table #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int LW       = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [LW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [LW-1:0] wr_data
);

  logic [LW-1:0] link_mem [CAPACITY];
  logic [LW-1:0] q_r;
  logic [LW-1:0] succ_r;
  logic          fresh_r;
  logic [LW-1:0] fill_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r     <= link_mem[rd_addr];
      succ_r  <= LW'(rd_addr) + LW'(1);
      fresh_r <= (LW'(rd_addr) >= fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (wr_en && (LW'(wr_addr) == fill_r)) begin
      fill_r <= fill_r + LW'(1);
    end
  end

  assign rd_data = fresh_r ? succ_r : q_r;

endmodule

// File: rtl/sbms_top_table.sv
// ----------------------------------------------------------------------------
// sbms_top_table
// Top-of-stack pointer per stack; a stack never written reads as null.
// ----------------------------------------------------------------------------
module sbms_top_table #(
  parameter int STACKS   = 8,
  parameter int CAPACITY = 64,
  parameter int SW       = 3,
  parameter int LW       = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [SW-1:0] rd_addr,
  output logic [LW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [SW-1:0] wr_addr,
  input  logic [LW-1:0] wr_data
);

  localparam logic [LW-1:0] NULL_IDX = LW'(CAPACITY);

  logic [LW-1:0]     top_mem [STACKS];
  logic [STACKS-1:0] valid_r;
  logic [LW-1:0]     q_r;
  logic              q_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      top_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r       <= top_mem[rd_addr];
      q_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = q_valid_r ? q_r : NULL_IDX;

endmodule

// File: rtl/shared_buffer_multi_stack.sv
// ----------------------------------------------------------------------------
// shared_buffer_multi_stack
// Several LIFO stacks sharing one entry store, managed by a linked free list.
//
// Input channel (in_valid/in_ready): in_action selects push or pop,
// in_stack_sel the stack, in_value the word to push (ignored on pop).
// Result channel (out_valid/out_ready): one transaction per input, with
// out_status (ok, push refused store full, pop refused stack empty) and
// out_popped_value (value of a successful pop, else zero).
// A push or a refused operation passes through S_IDLE and S_LOOK, a
// successful pop also through S_POP: the top pointer and then the link word
// are read from synchronous memories, one dependent read per cycle, before
// the write-back. The result register is loaded in the last of those states,
// so out_valid rises after S_LOOK for a push or a refused operation and
// after S_POP for a successful pop.
// in_ready is high while no transaction is in progress, also while a
// result waits in the output register.
// If the receiver stalls with a result still held, the next transaction
// waits in its final cycle and writes nothing until the register frees.
// Reset empties all stacks and returns every entry to the free list at once.
// ----------------------------------------------------------------------------
module shared_buffer_multi_stack
  import sbms_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int STACKS     = STACKS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [SEL_W-1:0]           in_stack_sel,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [VALUE_W-1:0]  out_popped_value
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int SW = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam int XW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam logic [LW-1:0] NULL_IDX = LW'(CAPACITY);
  localparam logic [8:0]    STACKS_LIM = 9'(STACKS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_POP
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    pop_r, pop_nxt;
  logic                    sel_ok_r, sel_ok_nxt;
  logic [SEL_W-1:0]        sel_r, sel_nxt;
  logic [DATA_WIDTH-1:0]   val_r, val_nxt;
  logic [LW-1:0]           slot_r, slot_nxt;
  logic [LW-1:0]           free_head_r, free_head_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]      out_value_r, out_value_nxt;

  logic [DATA_WIDTH-1:0]   ent_mem [CAPACITY];
  logic [DATA_WIDTH-1:0]   ent_q_r;
  logic                    ent_rd_en, ent_wr_en;
  logic [AW-1:0]           ent_rd_addr, ent_wr_addr;
  logic [XW-1:0]           ent_q_ext;

  logic                    link_rd_en, link_wr_en;
  logic [AW-1:0]           link_rd_addr, link_wr_addr;
  logic [LW-1:0]           link_rd_data, link_wr_data;

  logic                    top_rd_en, top_wr_en;
  logic [SW-1:0]           top_addr;
  logic [LW-1:0]           top_rd_data, top_wr_data;

  logic                    accept;
  logic                    out_free;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign top_addr  = SW'(sel_r);
  assign ent_q_ext = XW'(ent_q_r);

  always_ff @(posedge clk) begin
    if (ent_wr_en) begin
      ent_mem[ent_wr_addr] <= val_r;
    end
    if (ent_rd_en) begin
      ent_q_r <= ent_mem[ent_rd_addr];
    end
  end

  sbms_link_table #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .LW       (LW)
  ) u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (link_rd_en),
    .rd_addr (link_rd_addr),
    .rd_data (link_rd_data),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data)
  );

  sbms_top_table #(
    .STACKS   (STACKS),
    .CAPACITY (CAPACITY),
    .SW       (SW),
    .LW       (LW)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (top_rd_en),
    .rd_addr (SW'(in_stack_sel)),
    .rd_data (top_rd_data),
    .wr_en   (top_wr_en),
    .wr_addr (top_addr),
    .wr_data (top_wr_data)
  );

  always_comb begin
    state_nxt      = state_r;
    pop_nxt        = pop_r;
    sel_ok_nxt     = sel_ok_r;
    sel_nxt        = sel_r;
    val_nxt        = val_r;
    slot_nxt       = slot_r;
    free_head_nxt  = free_head_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;

    in_ready       = (state_r == S_IDLE);

    top_rd_en      = 1'b0;
    top_wr_en      = 1'b0;
    top_wr_data    = free_head_r;
    link_rd_en     = 1'b0;
    link_rd_addr   = free_head_r[AW-1:0];
    link_wr_en     = 1'b0;
    link_wr_addr   = free_head_r[AW-1:0];
    link_wr_data   = top_rd_data;
    ent_rd_en      = 1'b0;
    ent_rd_addr    = top_rd_data[AW-1:0];
    ent_wr_en      = 1'b0;
    ent_wr_addr    = free_head_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pop_nxt    = in_action;
          sel_nxt    = in_stack_sel;
          sel_ok_nxt = (9'(in_stack_sel) < STACKS_LIM);
          val_nxt    = DATA_WIDTH'($unsigned(in_value));
          top_rd_en  = 1'b1;
          link_rd_en = 1'b1;
          state_nxt  = S_LOOK;
        end
      end
      S_LOOK: begin
        slot_nxt = top_rd_data;
        if (!sel_ok_r || (!pop_r && free_head_r == NULL_IDX)
            || (pop_r && top_rd_data == NULL_IDX)) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pop_r ? ST_EMPTY : ST_FULL;
            out_value_nxt  = '0;
            state_nxt      = S_IDLE;
          end
        end else if (pop_r == ACT_POP) begin
          link_rd_en   = 1'b1;
          link_rd_addr = top_rd_data[AW-1:0];
          ent_rd_en    = 1'b1;
          state_nxt    = S_POP;
        end else if (out_free) begin
          ent_wr_en      = 1'b1;
          link_wr_en     = 1'b1;
          top_wr_en      = 1'b1;
          free_head_nxt  = link_rd_data;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = '0;
          state_nxt      = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          top_wr_en      = 1'b1;
          top_wr_data    = link_rd_data;
          link_wr_en     = 1'b1;
          link_wr_addr   = slot_r[AW-1:0];
          link_wr_data   = free_head_r;
          free_head_nxt  = slot_r;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = ent_q_ext[VALUE_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_head_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pop_r        <= pop_nxt;
    sel_r        <= sel_nxt;
    sel_ok_r     <= sel_ok_nxt;
    val_r        <= val_nxt;
    slot_r       <= slot_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_value_r;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for shared_buffer_multi_stack. Each accepted push or
// pop runs through a local model of the linked stacks and their free list.
// A scoreboard compares every result transaction against the model.
// Covers directed edge values, filling and emptying of the whole store, random
// push/pop mixes, sender pauses, and long output stalls with input backpressure.
// ----------------------------------------------------------------------------
module tb;
  import sbms_pkg::*;

  localparam int CAP           = CAPACITY_DEF;
  localparam int NSTK          = STACKS_DEF;
  localparam int NULL_IDX      = CAP;
  localparam int LONG_HOLD     = 200;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    status_t            status;
    logic [VALUE_W-1:0] data;
  } stack_result_t;

  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic                      in_action    = ACT_PUSH;
  logic [SEL_W-1:0]          in_stack_sel = '0;
  logic signed [VALUE_W-1:0] in_value     = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic [STATUS_W-1:0]       out_status;
  logic signed [VALUE_W-1:0] out_popped_value;

  // model of the shared store
  logic [VALUE_W-1:0] entry_data [CAP];
  int unsigned        entry_link [CAP];
  int unsigned        stack_top [NSTK];
  int unsigned        stack_depth [NSTK];
  int unsigned        free_slot;
  int unsigned        used_slots;

  stack_result_t pending_results[$];
  int            fail_count = 0;
  int            n_push = 0, n_pop = 0, n_full = 0, n_empty = 0;
  bit            tx_calm = 1'b0;
  bit            rx_calm = 1'b0;
  int            hold_req = 0;

  shared_buffer_multi_stack i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_stack_sel     (in_stack_sel),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_popped_value (out_popped_value)
  );

  always #1 clk = ~clk;

  function automatic void clear_store_model();
    for (int i = 0; i < CAP; i++) begin
      entry_data[i] = '0;
      entry_link[i] = i + 1;
    end
    for (int s = 0; s < NSTK; s++) begin
      stack_top[s]   = NULL_IDX;
      stack_depth[s] = 0;
    end
    free_slot  = 0;
    used_slots = 0;
  endfunction

  function automatic stack_result_t stack_op_outcome(action_t act, logic [SEL_W-1:0] sel,
                                                     logic [VALUE_W-1:0] data);
    stack_result_t r;
    int unsigned   slot;
    r.status = ST_OK;
    r.data   = '0;
    if (act == ACT_PUSH) begin
      if (free_slot >= NULL_IDX) begin
        r.status = ST_FULL;
      end else begin
        slot             = free_slot;
        entry_data[slot] = data;
        free_slot        = entry_link[slot];
        entry_link[slot] = stack_top[sel];
        stack_top[sel]   = slot;
        stack_depth[sel]++;
        used_slots++;
      end
    end else begin
      slot = stack_top[sel];
      if (slot >= NULL_IDX) begin
        r.status = ST_EMPTY;
      end else begin
        stack_top[sel]   = entry_link[slot];
        entry_link[slot] = free_slot;
        free_slot        = slot;
        r.data           = entry_data[slot];
        stack_depth[sel]--;
        used_slots--;
      end
    end
    return r;
  endfunction

  task automatic send_op(input action_t act, input logic [SEL_W-1:0] sel,
                         input logic [VALUE_W-1:0] data);
    int            gap;
    stack_result_t r;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_stack_sel <= sel;
    in_value     <= data;
    do @(posedge clk); while (!in_ready);
    r = stack_op_outcome(act, sel, data);
    pending_results.insert(pending_results.size(), r);
    if (act == ACT_PUSH) n_push++;
    else n_pop++;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_EMPTY) n_empty++;
  endtask

  // sender stops and waits for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SEL_W-1:0] pick_busy_stack();
    logic [SEL_W-1:0] s;
    s = SEL_W'($urandom_range(0, NSTK - 1));
    if (used_slots != 0) begin
      while (stack_depth[s] == 0) s = SEL_W'($urandom_range(0, NSTK - 1));
    end
    return s;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0:       return {1'b0, {(VALUE_W-1){1'b1}}};
      1:       return {1'b1, {(VALUE_W-1){1'b0}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    tx_calm = 1'b0;
    send_op(ACT_POP,  3'd0, 32'h0000_0000);
    send_op(ACT_POP,  3'd7, 32'hFFFF_FFFF);
    send_op(ACT_PUSH, 3'd0, 32'h7FFF_FFFF);
    send_op(ACT_PUSH, 3'd7, 32'h8000_0000);
    send_op(ACT_PUSH, 3'd3, 32'h0000_0000);
    send_op(ACT_PUSH, 3'd3, 32'hFFFF_FFFF);
    send_op(ACT_PUSH, 3'd5, 32'h5555_5555);
    send_op(ACT_PUSH, 3'd6, 32'hAAAA_AAAA);
    send_op(ACT_PUSH, 3'd1, 32'h0000_0001);
    send_op(ACT_PUSH, 3'd2, 32'h1234_5678);
    send_op(ACT_POP,  3'd3, 32'h0000_0000);
    send_op(ACT_POP,  3'd3, 32'h0000_0000);
    send_op(ACT_POP,  3'd3, 32'h0000_0000);
    send_op(ACT_POP,  3'd7, 32'h0000_0000);
    send_op(ACT_POP,  3'd0, 32'h0000_0000);
    send_op(ACT_POP,  3'd5, 32'h0000_0000);
    send_op(ACT_POP,  3'd6, 32'h0000_0000);
    send_op(ACT_POP,  3'd1, 32'h0000_0000);
    send_op(ACT_POP,  3'd2, 32'h0000_0000);
    send_op(ACT_POP,  3'd4, 32'h0000_0000);
    send_op(ACT_PUSH, 3'd4, 32'hC001_D00D);
    send_op(ACT_POP,  3'd4, 32'h0000_0000);
  endtask

  // fill the whole store, try pushes while full, then empty it again and try pops
  task automatic test_store_full(input bit one_stack, input bit calm);
    logic [SEL_W-1:0] sel;
    tx_calm = calm;
    sel     = SEL_W'($urandom_range(0, NSTK - 1));
    while (used_slots < CAP) begin
      if (!one_stack) sel = SEL_W'($urandom_range(0, NSTK - 1));
      send_op(ACT_PUSH, sel, rand_value());
    end
    repeat (3) send_op(ACT_PUSH, SEL_W'($urandom_range(0, NSTK - 1)), rand_value());
    while (used_slots > 0) begin
      if ($urandom_range(0, 99) < 85) sel = pick_busy_stack();
      else sel = SEL_W'($urandom_range(0, NSTK - 1));
      send_op(ACT_POP, sel, $urandom());
    end
    repeat (2) send_op(ACT_POP, SEL_W'($urandom_range(0, NSTK - 1)), $urandom());
  endtask

  task automatic test_random_mix(input int phases, input int per_phase);
    int               push_pct;
    bit               focus;
    logic [SEL_W-1:0] base_sel, sel;
    action_t          act;
    for (int p = 0; p < phases; p++) begin
      push_pct = $urandom_range(10, 90);
      focus    = ($urandom_range(0, 2) == 0);
      base_sel = SEL_W'($urandom_range(0, NSTK - 1));
      tx_calm  = ($urandom_range(0, 3) == 0);
      rx_calm <= ($urandom_range(0, 3) == 0);
      for (int k = 0; k < per_phase; k++) begin
        act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
        if (focus) sel = base_sel ^ SEL_W'($urandom_range(0, 1));
        else sel = SEL_W'($urandom_range(0, NSTK - 1));
        if (act == ACT_POP && !focus && $urandom_range(0, 99) < 80) sel = pick_busy_stack();
        send_op(act, sel, rand_value());
      end
    end
    rx_calm <= 1'b0;
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    tx_calm = 1'b1;
    hold_req <= hold_req + 1;
    repeat (30) begin
      send_op(($urandom_range(0, 1) != 0) ? ACT_POP : ACT_PUSH,
              SEL_W'($urandom_range(0, NSTK - 1)), rand_value());
    end
    drain();
  endtask

  task automatic test_sender_pause();
    tx_calm = 1'b0;
    repeat (2) begin
      repeat (40) begin
        send_op(($urandom_range(0, 2) == 0) ? ACT_POP : ACT_PUSH,
                SEL_W'($urandom_range(0, NSTK - 1)), rand_value());
      end
      drain();
    end
  endtask

  // result receiver: random stalls per transaction plus requested long holds
  initial begin : receiver
    int pause_left;
    int hold_done;
    int wait_n;
    pause_left = 0;
    hold_done  = 0;
    forever begin
      @(posedge clk);
      if (pause_left > 0) begin
        pause_left--;
        out_ready <= 1'b0;
      end else if (hold_req != hold_done) begin
        hold_done++;
        pause_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        wait_n = rx_calm ? 0 : $urandom_range(0, 7);
        if (wait_n > 0) pause_left = wait_n - 1;
        out_ready <= (wait_n == 0);
      end else begin
        out_ready <= rst_n;
      end
    end
  end

  always @(posedge clk) begin
    stack_result_t r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: status %0d, popped_value %h",
               out_status, out_popped_value);
        fail_count++;
      end else begin
        r = pending_results.pop_front();
        if (out_status !== r.status) begin
          $error("status mismatch: expected %0d, actual %0d", r.status, out_status);
          fail_count++;
        end
        if (out_popped_value !== r.data) begin
          $error("popped_value mismatch: expected %h, actual %h", r.data,
                 out_popped_value);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    clear_store_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_store_full(1'b0, 1'b0);
    test_backpressure();
    test_random_mix(20, 50);
    test_store_full(1'b1, 1'b1);
    test_sender_pause();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    $display("Ran %0d transactions: %0d pushes and %0d pops across %0d stacks.",
             n_push + n_pop, n_push, n_pop, NSTK);
    $display("Store-full refusals: %0d, empty-stack refusals: %0d.", n_full, n_empty);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
